// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL. Simulation gets the checks, synthesis gets nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check prop at every rising edge of clk, skipped while rst is high.
`define MEXP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

// Check prop at every rising edge of clk, reset included.
`define MEXP_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");

`else

`define MEXP_ASSERT(label, clk, rst, prop)
`define MEXP_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== design/mexp_pkg.sv =====
package mexp_pkg;

   localparam int DATA_W        = 32;
   localparam int WIDTH_DEFAULT = 32;
   localparam int CSR_IDX_W     = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_EXPONENT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS  = 1'd1;

   localparam logic [DATA_W-1:0] RESET_EXPONENT = 32'd65537;
   localparam logic [DATA_W-1:0] RESET_MODULUS  = 32'd1;

   // Operand selection of the shared modular multiplier
   typedef enum logic [1:0] {
      SEL_REDUCE,
      SEL_MUL,
      SEL_SQR
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        mul_start;
      logic        mul_step;
      logic        shift_exp;
      logic        emit;
      mul_sel_type sel;
   } cmd_type;

   typedef struct packed {
      logic mod_zero;
      logic exp_zero;
      logic exp_bit;
      logic mul_last;
   } sts_type;

endpackage

// ===== design/mexp_if.sv =====
interface mexp_req_if;
   logic                       valid;
   logic                       ready;
   logic [mexp_pkg::DATA_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface mexp_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [mexp_pkg::DATA_W-1:0] result;

   modport source (output valid, output result, input ready);
   modport sink (input valid, input result, output ready);
endinterface

// ===== design/mexp_ctrl.sv =====
`include "assert_macros.svh"

module mexp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  mexp_pkg::sts_type sts,
   output mexp_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RED_START,
      ST_RED_RUN,
      ST_BIT,
      ST_MUL_START,
      ST_MUL_RUN,
      ST_SQR_START,
      ST_SQR_RUN,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '{load: 1'b0, mul_start: 1'b0, mul_step: 1'b0, shift_exp: 1'b0,
              emit: 1'b0, sel: mexp_pkg::SEL_REDUCE};
      case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
         end
         ST_RED_START: begin
            cmd.mul_start = 1'b1;
            cmd.sel       = mexp_pkg::SEL_REDUCE;
         end
         ST_MUL_START: begin
            cmd.mul_start = 1'b1;
            cmd.sel       = mexp_pkg::SEL_MUL;
         end
         ST_SQR_START: begin
            cmd.mul_start = 1'b1;
            cmd.sel       = mexp_pkg::SEL_SQR;
         end
         ST_RED_RUN, ST_MUL_RUN: begin
            cmd.mul_step = 1'b1;
         end
         ST_SQR_RUN: begin
            cmd.mul_step  = 1'b1;
            cmd.shift_exp = sts.mul_last;
         end
         ST_FINISH: begin
            // load the output register only once it is free
            cmd.emit = !rsp_valid_ff || rsp_ready;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= sts.mod_zero ? ST_FINISH : ST_RED_START;
               end
            end
            ST_RED_START: begin
               state_ff <= ST_RED_RUN;
            end
            ST_RED_RUN: begin
               if (sts.mul_last) begin
                  state_ff <= ST_BIT;
               end
            end
            ST_BIT: begin
               if (sts.exp_zero) begin
                  state_ff <= ST_FINISH;
               end else if (sts.exp_bit) begin
                  state_ff <= ST_MUL_START;
               end else begin
                  state_ff <= ST_SQR_START;
               end
            end
            ST_MUL_START: begin
               state_ff <= ST_MUL_RUN;
            end
            ST_MUL_RUN: begin
               if (sts.mul_last) begin
                  state_ff <= ST_SQR_START;
               end
            end
            ST_SQR_START: begin
               state_ff <= ST_SQR_RUN;
            end
            ST_SQR_RUN: begin
               if (sts.mul_last) begin
                  state_ff <= ST_BIT;
               end
            end
            ST_FINISH: begin
               if (cmd.emit) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `MEXP_ASSERT(a_emit_into_free_slot, clock, reset, cmd.emit |-> (!rsp_valid_ff || rsp_ready))
   `MEXP_ASSERT(a_start_step_exclusive, clock, reset, !(cmd.mul_start && cmd.mul_step))
   `MEXP_ASSERT(a_emit_shows_result, clock, reset, cmd.emit |=> rsp_valid_ff)
   `MEXP_ASSERT(a_load_only_idle, clock, reset, cmd.load |-> (state_ff == ST_IDLE))

endmodule

// ===== design/mexp_datapath.sv =====
module mexp_datapath #(
   parameter int WIDTH = mexp_pkg::WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [mexp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mexp_pkg::DATA_W-1:0]     csr_wdata,
   input  logic [mexp_pkg::DATA_W-1:0]     req_value,
   input  mexp_pkg::cmd_type               cmd,
   output mexp_pkg::sts_type               sts,
   output logic [mexp_pkg::DATA_W-1:0]     result
);

   localparam int CNT_W = $clog2(WIDTH);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

   logic [mexp_pkg::DATA_W-1:0] exponent_cfg_ff;
   logic [mexp_pkg::DATA_W-1:0] modulus_cfg_ff;

   logic [WIDTH-1:0]      base_ff;
   logic [WIDTH-1:0]      acc_ff;
   logic [WIDTH-1:0]      exp_ff;
   logic [WIDTH-1:0]      ma_ff;
   logic [WIDTH-1:0]      mb_ff;
   logic [WIDTH-1:0]      mr_ff;
   logic [CNT_W-1:0]      cnt_ff;
   mexp_pkg::mul_sel_type sel_ff;
   logic [mexp_pkg::DATA_W-1:0] result_ff;

   logic [WIDTH-1:0] modulus;
   logic [WIDTH-1:0] addend;
   logic [WIDTH+1:0] sum;
   logic [WIDTH+1:0] n1;
   logic [WIDTH+1:0] n2;
   logic [WIDTH-1:0] mr_in;
   logic [WIDTH-1:0] ma_in;
   logic [WIDTH-1:0] mb_in;
   logic             mul_last;

   assign modulus  = modulus_cfg_ff[WIDTH-1:0];
   assign mul_last = (cnt_ff == CNT_LAST);

   // One interleaved step: r = (2r + a_bit * b) mod n, with r < n and b <= n
   always_comb begin
      addend = ma_ff[WIDTH-1] ? mb_ff : '0;
      sum    = {1'b0, mr_ff, 1'b0} + {2'b00, addend};
      n1     = {2'b00, modulus};
      n2     = {1'b0, modulus, 1'b0};
      if (sum >= n2) begin
         mr_in = WIDTH'(sum - n2);
      end else if (sum >= n1) begin
         mr_in = WIDTH'(sum - n1);
      end else begin
         mr_in = sum[WIDTH-1:0];
      end
   end

   always_comb begin
      case (cmd.sel)
         mexp_pkg::SEL_REDUCE: begin
            ma_in = base_ff;
            mb_in = WIDTH'(1);
         end
         mexp_pkg::SEL_MUL: begin
            ma_in = acc_ff;
            mb_in = base_ff;
         end
         mexp_pkg::SEL_SQR: begin
            ma_in = base_ff;
            mb_in = base_ff;
         end
         default: begin
            ma_in = base_ff;
            mb_in = base_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exponent_cfg_ff <= mexp_pkg::RESET_EXPONENT;
         modulus_cfg_ff  <= mexp_pkg::RESET_MODULUS;
      end else if (csr_we) begin
         if (csr_index == mexp_pkg::CSR_EXPONENT) begin
            exponent_cfg_ff <= csr_wdata;
         end else if (csr_index == mexp_pkg::CSR_MODULUS) begin
            modulus_cfg_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         base_ff <= req_value[WIDTH-1:0];
         acc_ff  <= WIDTH'(1);
         exp_ff  <= exponent_cfg_ff[WIDTH-1:0];
      end
      if (cmd.mul_start) begin
         ma_ff  <= ma_in;
         mb_ff  <= mb_in;
         mr_ff  <= '0;
         cnt_ff <= '0;
         sel_ff <= cmd.sel;
      end else if (cmd.mul_step) begin
         ma_ff  <= {ma_ff[WIDTH-2:0], 1'b0};
         mr_ff  <= mr_in;
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (mul_last) begin
            if (sel_ff == mexp_pkg::SEL_MUL) begin
               acc_ff <= mr_in;
            end else begin
               base_ff <= mr_in;
            end
         end
      end
      if (cmd.shift_exp) begin
         exp_ff <= exp_ff >> 1;
      end
      if (cmd.emit) begin
         result_ff <= (modulus == '0) ? '0 : mexp_pkg::DATA_W'(acc_ff);
      end
   end

   assign sts.mod_zero = (modulus == '0);
   assign sts.exp_zero = (exp_ff == '0);
   assign sts.exp_bit  = exp_ff[0];
   assign sts.mul_last = mul_last;
   assign result       = result_ff;

endmodule

// ===== design/modular_exponentiation.sv =====
// Modular exponentiation: result = value ^ exponent mod modulus (RSA on one number).
// Configuration: csr_we / csr_index / csr_wdata write the key exponent (index 0,
// reset 65537) and the key modulus (index 1, reset 1). Write them only while idle.
// Request channel req_chan: one value per request, taken when valid and ready meet.
// Response channel rsp_chan: one result per request, held until ready is seen.
// Work: the value is first reduced modulo the modulus, then the exponent is walked
// from its least significant bit; each set bit costs one modular multiply and every
// bit one modular square. One shared bit-serial multiplier does all of it, one
// multiplier bit per cycle. One request at a time. A modulus of zero skips the work
// and answers 0.
// Back-pressure: the result sits in an output register; the engine accepts the next
// request while it waits and only stalls at the end of that request's work.
// Reset (synchronous, active high): drop any request in flight, clear rsp valid and
// restore the reset key.
module modular_exponentiation #(
   parameter int WIDTH = mexp_pkg::WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [mexp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mexp_pkg::DATA_W-1:0]    csr_wdata,
   mexp_req_if.sink                       req_chan,
   mexp_rsp_if.source                     rsp_chan
);

   mexp_pkg::cmd_type cmd;
   mexp_pkg::sts_type sts;

   // Sequencer: walks reduce, multiply and square steps and owns both handshakes
   mexp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: key registers, base / accumulator / exponent and the serial multiplier
   mexp_datapath #(
      .WIDTH (WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_value (req_chan.value),
      .cmd       (cmd),
      .sts       (sts),
      .result    (rsp_chan.result)
   );

endmodule
